@@ rtl/core/dedup_event_set_table_macros.svh @@
// Assertion macros used by det_ctrl of the event set table RTL.
// Depends on: a clk and an active-low rst_n in the including module's scope.
`ifndef DEDUP_EVENT_SET_TABLE_MACROS_SVH
`define DEDUP_EVENT_SET_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/det_pkg.sv @@
// Types, constants and helpers for the event set table.
// Used by det_ctrl and dedup_event_set_table; no dependencies.
`timescale 1ns / 1ps

package det_pkg;

  localparam int KEY_W        = 34;
  localparam int CNT_OUT_W    = 8;
  localparam int DEF_CAPACITY = 128;

  // Command codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [1:0] category;
    logic [7:0] board;
    logic [7:0] device;
    logic [7:0] io_kind;
    logic [7:0] event_code;
  } in_t;

  typedef struct packed {
    logic                 found;
    logic                 overwrote;
    logic                 silence;
    logic [CNT_OUT_W-1:0] entry_count;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_UPDATE
  } det_state_t;

  // Key layout, top bit down: category, board, device, io_kind, event_code
  function automatic logic [KEY_W-1:0] pack_key(input in_t item);
    pack_key = {item.category, item.board, item.device, item.io_kind, item.event_code};
  endfunction

endpackage

@@ rtl/core/dedup_event_set_table.sv @@
// Event set table: one result beat per input beat, one item at a time. An item
// passes an accept state, a read and a compare per entry searched, on a removal
// hit a read and a write per entry shifted plus a closing read, and a commit state,
// paced by the single RAM port pair. Commit also waits while the last result is held.
// A new beat is taken once the previous commit is done, even if its result waits.
// Synchronous active-low reset clears state, count, write pointer and out_valid only.
`timescale 1ns / 1ps

module dedup_event_set_table
  import det_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic             busy;
  logic             acc;
  logic             res_free;
  logic             res_load;
  out_t             res;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [KEY_W-1:0] ram_rdata;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r;

  assign in_stall = busy;
  assign acc      = in_valid && !in_stall;
  assign res_free = !out_valid_r || !out_stall;

  det_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_item   (in_data),
    .busy      (busy),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  det_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: holds a result beat until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/det_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module det_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/det_ctrl.sv @@
// Sequencer for the event set table: linear search, shift-down on removal,
// append or round-robin overwrite on add. Depends on det_pkg and the macros header.
`timescale 1ns / 1ps
`include "dedup_event_set_table_macros.svh"

module det_ctrl
  import det_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  in_t                         in_item,
  output logic                        busy,
  input  logic                        res_free,
  output logic                        res_load,
  output out_t                        res,
  output logic                        ram_we,
  output logic [$clog2(CAPACITY)-1:0] ram_waddr,
  output logic [KEY_W-1:0]            ram_wdata,
  output logic [$clog2(CAPACITY)-1:0] ram_raddr,
  input  logic [KEY_W-1:0]            ram_rdata
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_C = IDX_W'(CAPACITY - 1);

  det_state_t       state_r, state_nxt;
  logic             cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             hit_r, hit_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] lw_r, lw_nxt;

  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W-1:0] cnt_dec2;
  logic [IDX_W-1:0] lw_wrap;

  assign idx_inc  = idx_r + 1'b1;
  assign cnt_dec  = cnt_r - 1'b1;
  assign cnt_dec2 = cnt_r - 2'd2;
  assign lw_wrap  = (lw_r == LAST_C) ? '0 : lw_r + 1'b1;
  assign busy     = (state_r != ST_IDLE);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      lw_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      lw_r    <= lw_nxt;
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    idx_r <= idx_nxt;
    hit_r <= hit_nxt;
  end

  // Next state, RAM access and result
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    cnt_nxt   = cnt_r;
    lw_nxt    = lw_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r[IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_r[IDX_W-1:0];
    res_load  = 1'b0;
    res       = '0;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          cmd_nxt   = in_item.cmd;
          key_nxt   = pack_key(in_item);
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = (cnt_r == '0) ? ST_UPDATE : ST_READ;
        end
      end

      // read address idx_r is presented; data lands next cycle
      ST_READ: begin
        state_nxt = ST_CMP;
      end

      ST_CMP: begin
        if (ram_rdata == key_r) begin
          hit_nxt   = 1'b1;
          state_nxt = (cmd_r == CMD_REMOVE) ? ST_SHIFT_RD : ST_UPDATE;
        end else if (idx_inc == cnt_r) begin
          state_nxt = ST_UPDATE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ST_READ;
        end
      end

      // shift-down: fetch entry idx+1 while one is left above
      ST_SHIFT_RD: begin
        if (idx_inc < cnt_r) begin
          ram_raddr = idx_inc[IDX_W-1:0];
          state_nxt = ST_SHIFT_WR;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end

      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_inc;
        state_nxt = ST_SHIFT_RD;
      end

      // commit table update together with the result beat
      ST_UPDATE: begin
        res.found = hit_r;
        if (res_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (cmd_r == CMD_ADD && !hit_r) begin
            ram_we    = 1'b1;
            ram_wdata = key_r;
            if (cnt_r != CAP_C) begin
              ram_waddr = cnt_r[IDX_W-1:0];
              lw_nxt    = cnt_r[IDX_W-1:0];
              cnt_nxt   = cnt_r + 1'b1;
            end else begin
              ram_waddr     = lw_wrap;
              lw_nxt        = lw_wrap;
              res.overwrote = 1'b1;
            end
          end else if (cmd_r == CMD_REMOVE && hit_r) begin
            cnt_nxt = cnt_dec;
            if (cnt_dec == '0) begin
              lw_nxt      = '0;
              res.silence = 1'b1;
            end else begin
              lw_nxt = cnt_dec2[IDX_W-1:0];
            end
          end
        end
        res.entry_count = CNT_OUT_W'(cnt_nxt);
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `DET_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CAP_C, "entry count above capacity")
  `DET_ASSERT_NOW(a_search_in_range, state_r == ST_READ, idx_r < cnt_r, "search past valid entries")
  `DET_ASSERT_NOW(a_we_states, ram_we, state_r == ST_UPDATE || state_r == ST_SHIFT_WR, "stray table write")
  `DET_ASSERT_NEXT(a_cnt_hold, state_r != ST_UPDATE, $stable(cnt_r), "count moved outside commit")

endmodule
